// ----- rtl/bitmap_block_allocator_top_macros.svh -----
// Assertion macros used by the allocator top level.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator implication check failed");
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator next-cycle check failed");
`else
`define BBA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/bba_pkg.sv -----
// Shared constants and types of the bitmap block allocator.
package bba_pkg;

   localparam int unsigned NBLOCKS   = 65536;
   localparam int unsigned BLK_W     = 16;
   localparam int unsigned CNT_W     = 17;
   // Highest exclusive block limit that the map can ever hold.
   localparam int unsigned LIM_CAP   = (NBLOCKS > 65536) ? 65536 : NBLOCKS;
   localparam int unsigned CNT_CEIL  = (NBLOCKS > 131071) ? 131071 : NBLOCKS;
   localparam int unsigned WORD_BITS = 6;
   localparam int unsigned WORD_W    = 1 << WORD_BITS;
   localparam int unsigned MAP_WORDS = (LIM_CAP + WORD_W - 1) / WORD_W;
   localparam int unsigned MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_MARK  = 2'd2;
   localparam logic [1:0] CMD_SETCNT = 2'd3;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NOFREE  = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   localparam logic CSR_FIRST_DATA_BLOCK = 1'b0;
   localparam logic CSR_BLOCK_COUNT      = 1'b1;

   typedef struct packed {
      logic              re;
      logic [MAP_AW-1:0] raddr;
      logic              we;
      logic [MAP_AW-1:0] waddr;
      logic [WORD_W-1:0] wdata;
   } ram_req_type;

endpackage

// ----- rtl/bba_map_ram.sv -----
// Used-block bitmap memory, one word per 64 blocks, registered read.
module bba_map_ram (
   input  logic                        clock,
   input  bba_pkg::ram_req_type        ram_req,
   output logic [bba_pkg::WORD_W-1:0]  ram_rdata
);
   import bba_pkg::*;

   logic [WORD_W-1:0] mem [MAP_WORDS];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

// ----- rtl/bba_ctrl.sv -----
// Command sequencer: clearing sweep, word scan for allocate, read-modify-write.
module bba_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_cmd,
   input  logic [bba_pkg::BLK_W-1:0]   req_block_number,
   input  logic [bba_pkg::CNT_W-1:0]   req_count_value,
   input  logic [bba_pkg::BLK_W-1:0]   first_block,
   input  logic [bba_pkg::CNT_W-1:0]   limit,
   output bba_pkg::ram_req_type        ram_req,
   input  logic [bba_pkg::WORD_W-1:0]  ram_rdata,
   output logic                        rsp_valid,
   output logic [bba_pkg::BLK_W-1:0]   rsp_given_block,
   output logic [1:0]                  rsp_status,
   output logic [bba_pkg::CNT_W-1:0]   rsp_free_total
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_SCAN   = 4'b1000
   } state_type;

   localparam logic [CNT_W-1:0]  CEIL      = CNT_W'(CNT_CEIL);
   localparam logic [MAP_AW-1:0] LAST_WORD = MAP_AW'(MAP_WORDS - 1);

   state_type         state_ff, state_in;
   logic [MAP_AW-1:0] addr_ff, addr_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [WORD_BITS-1:0] bit_ff, bit_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]  given_ff, given_in;
   logic [1:0]        status_ff, status_in;
   logic [CNT_W-1:0]  free_ff, free_in;

   logic [CNT_W-1:0]  limit_m1;
   logic [MAP_AW-1:0] first_word, last_word, req_word;
   logic [WORD_W-1:0] lo_mask, hi_mask, cand, lowest, one_bit;
   logic [WORD_BITS-1:0] low_idx;
   logic              first_out, req_out;

   assign limit_m1   = limit - CNT_W'(1);
   assign first_word = first_block[WORD_BITS +: MAP_AW];
   assign last_word  = limit_m1[WORD_BITS +: MAP_AW];
   assign req_word   = req_block_number[WORD_BITS +: MAP_AW];
   assign first_out  = {1'b0, first_block} >= limit;
   assign req_out    = {1'b0, req_block_number} >= limit;

   // Candidate bits of the word under scan: inside [first_block, limit).
   always_comb begin
      lo_mask = '1;
      hi_mask = '1;
      if (addr_ff == first_word) begin
         lo_mask = {WORD_W{1'b1}} << first_block[WORD_BITS-1:0];
      end
      if (addr_ff == last_word) begin
         hi_mask = {WORD_W{1'b1}} >> (~limit_m1[WORD_BITS-1:0]);
      end
      cand   = ~ram_rdata & lo_mask & hi_mask;
      lowest = cand & (~cand + WORD_W'(1));
      low_idx = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (lowest[i]) begin
            low_idx = low_idx | WORD_BITS'(i);
         end
      end
   end

   assign one_bit = WORD_W'(1) << bit_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cmd_in       = cmd_ff;
      bit_in       = bit_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      given_in     = '0;
      status_in    = STATUS_DONE;
      free_in      = count_ff;
      ram_req      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = addr_ff;
            ram_req.wdata = '0;
            addr_in       = addr_ff + MAP_AW'(1);
            if (addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_cmd;
               bit_in = req_block_number[WORD_BITS-1:0];
               unique case (req_cmd) inside
                  CMD_ALLOC: begin
                     if (first_out) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STATUS_NOFREE;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = first_word;
                        addr_in       = first_word;
                        state_in      = ST_SCAN;
                     end
                  end
                  CMD_FREE, CMD_MARK: begin
                     if (req_out) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STATUS_IGNORED;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = req_word;
                        addr_in       = req_word;
                        state_in      = ST_MODIFY;
                     end
                  end
                  default: begin
                     count_in     = (req_count_value > CEIL) ? CEIL : req_count_value;
                     free_in      = count_in;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
            ram_req.waddr = addr_ff;
            if (cmd_ff == CMD_MARK) begin
               ram_req.we    = 1'b1;
               ram_req.wdata = ram_rdata | one_bit;
            end else if ((ram_rdata & one_bit) != '0) begin
               ram_req.we    = 1'b1;
               ram_req.wdata = ram_rdata & ~one_bit;
               if (count_ff < CEIL) begin
                  count_in = count_ff + CNT_W'(1);
               end
               free_in = count_in;
            end else begin
               status_in = STATUS_IGNORED;
            end
         end
         ST_SCAN: begin
            if (cand != '0) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = addr_ff;
               ram_req.wdata = ram_rdata | lowest;
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
               end
               free_in      = count_in;
               given_in     = BLK_W'({addr_ff, low_idx});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (addr_ff == last_word) begin
               status_in    = STATUS_NOFREE;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = addr_ff + MAP_AW'(1);
               addr_in       = addr_ff + MAP_AW'(1);
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      bit_ff    <= bit_in;
      given_ff  <= given_in;
      status_ff <= status_in;
      free_ff   <= free_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_given_block = given_ff;
   assign rsp_status      = status_ff;
   assign rsp_free_total  = free_ff;

endmodule

// ----- rtl/bitmap_block_allocator_top.sv -----
// Top level of the bitmap first-fit block allocator.
//
// Commands enter on start/req_* and are taken when start is high and busy
// is low. Every command gives exactly one response word, shown for one
// cycle with rsp_valid high; the receiver cannot stall it.
// Set-counter commands, and free, mark or allocate commands outside the
// valid block range, answer in the cycle after acceptance.
// Free and mark do a read-modify-write of one bitmap word.
// Allocate reads one 64-block word of the bitmap per cycle through the
// single memory read port, from the word of first_data_block up to the
// last valid word.
// After reset the block sweeps the bitmap to zero, one word a cycle, with
// busy high; configuration writes are taken at any time and should be
// issued only while no command is in flight.
// Register 0 is first_data_block, register 1 is block_count.
`include "bitmap_block_allocator_top_macros.svh"
module bitmap_block_allocator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_cmd,
   input  logic [bba_pkg::BLK_W-1:0]  req_block_number,
   input  logic [bba_pkg::CNT_W-1:0]  req_count_value,
   output logic                       rsp_valid,
   output logic [bba_pkg::BLK_W-1:0]  rsp_given_block,
   output logic [1:0]                 rsp_status,
   output logic [bba_pkg::CNT_W-1:0]  rsp_free_total,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [bba_pkg::CNT_W-1:0]  csr_wdata
);
   import bba_pkg::*;

   localparam logic [CNT_W-1:0] CAP = CNT_W'(LIM_CAP);

   logic [BLK_W-1:0]  first_block_ff;
   logic [CNT_W-1:0]  block_count_ff;
   logic [CNT_W-1:0]  limit;
   ram_req_type       ram_req;
   logic [WORD_W-1:0] ram_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_block_ff <= '0;
         block_count_ff <= CNT_W'(65536);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FIRST_DATA_BLOCK) begin
            first_block_ff <= csr_wdata[BLK_W-1:0];
         end else begin
            block_count_ff <= csr_wdata;
         end
      end
   end

   assign limit = (block_count_ff > CAP) ? CAP : block_count_ff;

   bba_map_ram u_map_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   bba_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_block_number (req_block_number),
      .req_count_value  (req_count_value),
      .first_block      (first_block_ff),
      .limit            (limit),
      .ram_req          (ram_req),
      .ram_rdata        (ram_rdata),
      .rsp_valid        (rsp_valid),
      .rsp_given_block  (rsp_given_block),
      .rsp_status       (rsp_status),
      .rsp_free_total   (rsp_free_total)
   );

   // An accepted command either answers at once or keeps the block busy.
   `BBA_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)
   // Only a successful allocate carries a nonzero block number.
   `BBA_ASSERT_IMPLY(a_given_zero, clock, reset, rsp_valid && rsp_status != STATUS_DONE,
                     rsp_given_block == '0)
   // The free counter never passes its ceiling.
   `BBA_ASSERT_IMPLY(a_count_ceiling, clock, reset, rsp_valid,
                     rsp_free_total <= CNT_W'(CNT_CEIL))
   // The memory is never written while a response word is being formed from idle.
   `BBA_ASSERT_IMPLY(a_no_write_idle, clock, reset, !busy, !ram_req.we)

endmodule

// ----- tb/sv/tb_bitmap_block_allocator_top.sv -----
// Self-checking testbench for the bitmap first-fit block allocator top level.
module tb_bitmap_block_allocator_top;
   import bba_pkg::*;

   typedef struct packed {
      logic [BLK_W-1:0] given_block;
      logic [1:0]       status;
      logic [CNT_W-1:0] free_total;
   } alloc_rsp_type;

   // Tracks the used-block map, the free counter and both registers, and
   // keeps the response words still owed by the block in command order.
   class allocator_mirror;
      bit               used_map [NBLOCKS];
      logic [CNT_W-1:0] free_count;
      logic [BLK_W-1:0] first_block;
      logic [CNT_W-1:0] block_total;
      alloc_rsp_type    awaited_rsp [$];
      int               mismatches;

      function new();
         free_count  = '0;
         first_block = '0;
         block_total = CNT_W'(65536);
         mismatches  = 0;
      endfunction

      // Exclusive upper bound of block numbers that count as valid.
      function int unsigned block_limit();
         int unsigned lim;
         lim = block_total;
         if (lim > NBLOCKS) lim = NBLOCKS;
         if (lim > 65536) lim = 65536;
         return lim;
      endfunction

      function void accept_command(logic [1:0] cmd, logic [BLK_W-1:0] blk,
                                   logic [CNT_W-1:0] cnt);
         int unsigned   lim;
         int unsigned   ceiling;
         int unsigned   b;
         alloc_rsp_type rsp;
         lim     = block_limit();
         ceiling = (NBLOCKS > 131071) ? 131071 : NBLOCKS;
         rsp     = '0;
         rsp.status = STATUS_DONE;
         case (cmd)
            CMD_ALLOC: begin
               rsp.status = STATUS_NOFREE;
               b = first_block;
               while (b < lim && used_map[b]) b++;
               if (b < lim) begin
                  used_map[b] = 1'b1;
                  // The counter floors at zero but the block is still handed out.
                  if (free_count > 0) free_count--;
                  rsp.given_block = BLK_W'(b);
                  rsp.status      = STATUS_DONE;
               end
            end
            CMD_FREE: begin
               if (blk < lim && used_map[blk]) begin
                  used_map[blk] = 1'b0;
                  if (free_count < ceiling) free_count++;
               end else begin
                  rsp.status = STATUS_IGNORED;
               end
            end
            CMD_MARK: begin
               if (blk < lim) used_map[blk] = 1'b1;
               else rsp.status = STATUS_IGNORED;
            end
            CMD_SETCNT: begin
               free_count = (cnt > ceiling) ? CNT_W'(ceiling) : cnt;
            end
         endcase
         rsp.free_total = free_count;
         awaited_rsp.push_back(rsp);
      endfunction

      function void compare_response(logic [BLK_W-1:0] given, logic [1:0] status,
                                     logic [CNT_W-1:0] free_total);
         alloc_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $error("unexpected response word: given_block %0d status %0d free_total %0d",
                   given, status, free_total);
            mismatches++;
            return;
         end
         want = awaited_rsp.pop_front();
         if (given !== want.given_block) begin
            $error("given_block: expected %0d, actual %0d", want.given_block, given);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (free_total !== want.free_total) begin
            $error("free_total: expected %0d, actual %0d", want.free_total, free_total);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_cmd;
   logic [BLK_W-1:0] req_block_number;
   logic [CNT_W-1:0] req_count_value;
   logic             rsp_valid;
   logic [BLK_W-1:0] rsp_given_block;
   logic [1:0]       rsp_status;
   logic [CNT_W-1:0] rsp_free_total;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_index;
   logic [CNT_W-1:0] csr_wdata;

   allocator_mirror mirror = new();
   int unsigned     sent = 0;

   bitmap_block_allocator_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_block_number (req_block_number),
      .req_count_value  (req_count_value),
      .rsp_valid        (rsp_valid),
      .rsp_given_block  (rsp_given_block),
      .rsp_status       (rsp_status),
      .rsp_free_total   (rsp_free_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // A response word is shown for one cycle and taken at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         mirror.compare_response(rsp_given_block, rsp_status, rsp_free_total);
   end

   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic issue_command(input logic [1:0] cmd, input logic [BLK_W-1:0] blk,
                                input logic [CNT_W-1:0] cnt, input bit no_idle);
      int unsigned gap;
      gap = no_idle ? 0 : idle_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_block_number <= blk;
      req_count_value  <= cnt;
      do @(posedge clock); while (busy !== 1'b0);
      mirror.accept_command(cmd, blk, cnt);
      sent++;
   endtask

   // Holds off new commands until every response word has come back.
   task automatic wait_all_answered();
      start <= 1'b0;
      do @(posedge clock); while (mirror.awaited_rsp.size() != 0);
   endtask

   // Writes both registers back to back; valid stays high between the two words.
   task automatic set_window(input logic [CNT_W-1:0] first_word,
                             input logic [CNT_W-1:0] count_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIRST_DATA_BLOCK;
      csr_wdata <= first_word;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mirror.first_block = first_word[BLK_W-1:0];
      csr_index <= CSR_BLOCK_COUNT;
      csr_wdata <= count_word;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mirror.block_total = count_word;
      csr_valid <= 1'b0;
   endtask

   task automatic random_command(input bit no_idle);
      int unsigned lim;
      int unsigned lo;
      int unsigned roll;
      int unsigned blk;
      int unsigned cnt;
      logic [1:0]  cmd;
      lim  = mirror.block_limit();
      lo   = mirror.first_block;
      roll = $urandom_range(0, 99);
      if (roll < 10 || lim == 0) blk = $urandom_range(0, 65535);
      else if (lo < lim && roll < 75) blk = $urandom_range(lo, lim - 1);
      else blk = $urandom_range(0, lim - 1);
      roll = $urandom_range(0, 99);
      if (roll < 40) cmd = CMD_ALLOC;
      else if (roll < 70) cmd = CMD_FREE;
      else if (roll < 85) cmd = CMD_MARK;
      else cmd = CMD_SETCNT;
      roll = $urandom_range(0, 99);
      if (roll < 40) cnt = $urandom_range(0, lim);
      else if (roll < 70) cnt = $urandom_range(0, 16);
      else if (roll < 85) cnt = $urandom_range(65530, 65540);
      else cnt = $urandom_range(0, 131071);
      issue_command(cmd, BLK_W'(blk), CNT_W'(cnt), no_idle);
   endtask

   initial begin
      int unsigned phase_items;
      int unsigned roll;
      int unsigned fdb;
      int unsigned count_reg;
      bit          no_idle;
      reset            = 1'b1;
      start            = 1'b0;
      req_cmd          = CMD_ALLOC;
      req_block_number = '0;
      req_count_value  = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_FIRST_DATA_BLOCK;
      csr_wdata        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Whole volume from block zero: counter ceiling, floor and double marks.
      issue_command(CMD_SETCNT, 16'd0, 17'h1FFFF, 1'b0);
      issue_command(CMD_FREE, 16'd5, 17'd0, 1'b0);
      issue_command(CMD_ALLOC, 16'hFFFF, 17'd0, 1'b0);
      issue_command(CMD_ALLOC, 16'd0, 17'h1FFFF, 1'b0);
      issue_command(CMD_SETCNT, 16'd0, 17'd65536, 1'b0);
      issue_command(CMD_FREE, 16'd0, 17'd0, 1'b0);
      issue_command(CMD_MARK, 16'hFFFF, 17'd0, 1'b0);
      issue_command(CMD_MARK, 16'hFFFF, 17'd0, 1'b0);
      issue_command(CMD_SETCNT, 16'd0, 17'd0, 1'b0);
      issue_command(CMD_ALLOC, 16'd0, 17'd0, 1'b0);

      // One-block window at the very top of the volume.
      wait_all_answered();
      set_window(17'd65535, 17'd65536);
      issue_command(CMD_ALLOC, 16'd0, 17'd0, 1'b0);
      issue_command(CMD_FREE, 16'hFFFF, 17'd0, 1'b0);
      issue_command(CMD_ALLOC, 16'd0, 17'd0, 1'b0);
      issue_command(CMD_ALLOC, 16'd0, 17'd0, 1'b0);

      // First data block beyond the block count leaves nothing to search.
      wait_all_answered();
      set_window({1'b1, 16'd20}, 17'd10);
      issue_command(CMD_ALLOC, 16'd0, 17'd0, 1'b0);
      issue_command(CMD_FREE, 16'hFFFF, 17'd0, 1'b0);
      issue_command(CMD_MARK, 16'd10, 17'd0, 1'b0);
      issue_command(CMD_MARK, 16'd9, 17'd0, 1'b0);

      wait_all_answered();
      set_window(17'd0, 17'd0);
      issue_command(CMD_ALLOC, 16'd0, 17'd0, 1'b0);
      issue_command(CMD_FREE, 16'd0, 17'd0, 1'b0);
      issue_command(CMD_MARK, 16'd0, 17'd0, 1'b0);

      // A block count above the map size is capped to the map.
      wait_all_answered();
      set_window(17'd0, 17'h1FFFF);
      issue_command(CMD_MARK, 16'd2, 17'd0, 1'b0);
      issue_command(CMD_ALLOC, 16'd0, 17'd0, 1'b0);
      issue_command(CMD_FREE, 16'hFFFF, 17'd0, 1'b0);
      issue_command(CMD_SETCNT, 16'd0, 17'd65537, 1'b0);

      while (sent < 1275) begin
         wait_all_answered();
         roll        = $urandom_range(0, 99);
         phase_items = $urandom_range(20, 60);
         if (roll < 50) begin
            fdb       = $urandom_range(0, 2000);
            count_reg = fdb + $urandom_range(1, 16);
         end else if (roll < 80) begin
            fdb       = $urandom_range(0, 64000);
            count_reg = fdb + $urandom_range(17, 1024);
         end else if (roll < 92) begin
            // Full-volume scans are slow, so these phases stay short.
            fdb         = $urandom_range(0, 255);
            count_reg   = $urandom_range(60000, 131071);
            phase_items = $urandom_range(4, 10);
         end else if (roll < 96) begin
            fdb       = $urandom_range(65530, 65535);
            count_reg = 65536;
         end else begin
            fdb       = $urandom_range(0, 65535);
            count_reg = $urandom_range(0, fdb);
         end
         set_window({1'($urandom_range(0, 1)), 16'(fdb)}, CNT_W'(count_reg));
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (phase_items) random_command(no_idle);
      end

      wait_all_answered();
      repeat (1100) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("bitmap_block_allocator_top: match");
      end else begin
         $display("bitmap_block_allocator_top: mismatch");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("bitmap_block_allocator_top: mismatch");
      $finish;
   end

endmodule
